>>> hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg - shared types and constants of the frustum box culling block
// Request codes, channel payloads, sequencer states and the control bundle
// of the shared shift-subtract unit.
// ----------------------------------------------------------------------------
package fbc_pkg;

	// Corner width: 32-bit centre plus 31-bit extent, kept exact.
	localparam int MUL_A_W = 34;

	typedef enum logic [1:0] {
		REQ_LOAD_VIEW = 2'd0,
		REQ_LOAD_PROJ = 2'd1,
		REQ_BUILD     = 2'd2,
		REQ_TEST      = 2'd3
	} req_code_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] entry_value;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0]        extent_x;
		logic [30:0]        extent_y;
		logic [30:0]        extent_z;
	} req_item_t;

	typedef struct packed {
		logic inside_res;
	} res_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BMUL,
		S_BDRAIN,
		S_BRAW,
		S_NSQ,
		S_NDRAIN,
		S_NROOT_GO,
		S_NROOT_WAIT,
		S_NDIV_GO,
		S_NDIV_WAIT,
		S_TEST,
		S_TDRAIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACC_VP,
		ACC_SQ,
		ACC_DOT
	} acc_kind_t;

	typedef struct packed {
		logic      first;
		logic      last;
		logic [1:0] col;
		acc_kind_t kind;
	} mul_tag_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} iter_ctl_t;

endpackage

>>> hdl/fbc_ifs.sv
// ----------------------------------------------------------------------------
// fbc_ifs - valid/ready channels of the frustum box culling block
// Request channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface fbc_req_if;
	logic                valid;
	logic                ready;
	fbc_pkg::req_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fbc_res_if;
	logic                valid;
	logic                ready;
	fbc_pkg::res_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/fbc_iter.sv
// ----------------------------------------------------------------------------
// fbc_iter - shared shift-subtract unit
// Restoring division (one quotient bit a cycle) or integer square root
// (one root bit a cycle) on one compare-subtract datapath.
// ----------------------------------------------------------------------------
module fbc_iter #(
	parameter int EW = 32,
	parameter int FB = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fbc_pkg::iter_ctl_t    ctl,
	input  logic [EW+FB-1:0]      num,
	input  logic [2*EW-1:0]       radicand,
	input  logic [EW:0]           divisor,
	output logic                  done,
	output logic [EW+FB-1:0]      result
);

	localparam int NW  = EW + FB;
	localparam int SQW = 2 * EW;
	localparam int LW  = EW + 1;
	localparam int RW  = EW + 3;
	localparam int SW  = (NW > SQW) ? NW : SQW;
	localparam int CW  = $clog2(SW + 1);

	logic          mode_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [SW-1:0] src_q;
	logic [LW-1:0] div_q;

	logic [RW-1:0] shifted;
	logic [RW-1:0] trial;
	logic          ge;

	always_comb begin
		if (mode_q) begin
			shifted = {rem_q[RW-3:0], src_q[SW-1:SW-2]};
			trial   = {quo_q[EW:0], 2'b01};
		end else begin
			shifted = {rem_q[RW-2:0], src_q[SW-1]};
			trial   = {2'b00, div_q};
		end
		ge = (shifted >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.sqrt_mode ? CW'(EW) : CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.sqrt_mode;
			div_q  <= divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			if (ctl.sqrt_mode)
				src_q <= SW'(radicand) << (SW - SQW);
			else
				src_q <= SW'(num) << (SW - NW);
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - trial) : shifted;
			quo_q <= {quo_q[NW-2:0], ge};
			src_q <= mode_q ? (src_q << 2) : (src_q << 1);
		end
	end

	assign done   = done_q;
	assign result = quo_q;

endmodule

>>> hdl/frustum_box_culling.sv
// ----------------------------------------------------------------------------
// frustum_box_culling - view frustum culling of axis-aligned boxes
// Loads view and projection entries, builds six normalised frustum planes
// and tests boxes against them with one shared multiplier and accumulator.
// Load: written straight from the request; the block stays idle and ready.
// Box test: 24 products (one per cycle), then S_TDRAIN and S_DONE, which waits
//   for a free result register. Build: matrix work per row, then per plane a
//   square sum, a square root and four divisions in the shift-subtract unit.
// Reset: identity view and projection, all-zero planes, channels empty.
// ----------------------------------------------------------------------------
module frustum_box_culling #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	fbc_req_if.sink      req,
	fbc_res_if.source    res
);

	// Stored words never exceed 32 bits.
	localparam int EW   = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int MAW  = fbc_pkg::MUL_A_W;
	localparam int PW   = MAW + EW;
	localparam int ACCW = PW + 2;
	localparam int NW   = EW + FB;
	localparam int LW   = EW + 1;
	localparam int SQW  = 2 * EW;

	localparam logic signed [EW-1:0]   WMAX   = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0]   WMIN   = {1'b1, {(EW-1){1'b0}}};
	localparam logic signed [ACCW-1:0] WMAX_X = ACCW'(WMAX);
	localparam logic signed [ACCW-1:0] WMIN_X = ACCW'(WMIN);
	localparam logic signed [MAW-1:0]  ONE_A  = MAW'(64'd1 << FB);
	// 1.0 on the diagonal, clipped where the format cannot hold it
	localparam logic signed [EW-1:0]   DIAG   =
		(FB < EW - 1) ? EW'(64'd1 << FB) : WMAX;

	function automatic logic signed [EW-1:0] sat_w(input logic signed [ACCW-1:0] x);
		if (x > WMAX_X)
			return WMAX;
		else if (x < WMIN_X)
			return WMIN;
		else
			return x[EW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Storage
	// ------------------------------------------------------------------
	logic signed [EW-1:0]  view_q  [16];
	logic signed [EW-1:0]  proj_q  [16];
	logic signed [EW-1:0]  plane_q [24];
	logic signed [EW-1:0]  raw_q   [24];
	logic signed [EW-1:0]  mrow_q  [4];
	logic signed [MAW-1:0] mn_q    [3];
	logic signed [MAW-1:0] mx_q    [3];

	fbc_pkg::state_t state_q, state_d;
	logic [3:0]      cnt_q;
	logic [1:0]      row_q;
	logic [2:0]      pl_q;
	logic [LW-1:0]   len_q;
	logic            rneg_q;
	logic            outside_q;
	logic            out_valid_q;
	logic            out_inside_q;

	// multiplier stage and accumulator
	logic signed [PW-1:0]   prod_s1;
	logic                   pv_s1;
	fbc_pkg::mul_tag_t      ptag_s1;
	logic signed [ACCW-1:0] acc_q;
	logic signed [ACCW-1:0] acc_sum;

	logic                   issue;
	logic signed [MAW-1:0]  mul_a;
	logic signed [EW-1:0]   mul_b;
	fbc_pkg::mul_tag_t      mul_tag;

	logic                   accept;
	logic                   res_free;
	logic [4:0]             sidx;
	logic signed [EW-1:0]   raw_sel;
	logic signed [EW-1:0]   pl_sel;
	logic [EW-1:0]          raw_abs;
	logic signed [EW-1:0]   raw_new;
	logic signed [ACCW-1:0] raw_sum;
	logic signed [EW-1:0]   entry_sat;
	logic signed [ACCW-1:0] q_x;
	logic signed [EW-1:0]   q_sat;
	logic                   adv;
	logic                   last_k;
	logic                   last_p;

	fbc_pkg::iter_ctl_t     iter_ctl;
	logic                   iter_done;
	logic [NW-1:0]          iter_res;

	assign accept    = req.valid && req.ready;
	assign res_free  = !out_valid_q || res.ready;
	assign sidx      = {pl_q, cnt_q[1:0]};
	assign raw_sel   = raw_q[sidx];
	assign pl_sel    = plane_q[sidx];
	assign raw_abs   = raw_sel[EW-1] ? EW'(-raw_sel) : EW'(raw_sel);
	assign entry_sat = sat_w(ACCW'(req.data.entry_value));
	assign last_k    = (cnt_q[1:0] == 2'd3);
	assign last_p    = (pl_q == 3'd5);
	assign adv       = (state_q == fbc_pkg::S_NDIV_GO && len_q == '0) ||
	                   (state_q == fbc_pkg::S_NDIV_WAIT && iter_done);

	// Quotient: zero-extend, apply the sign, clip.
	assign q_x   = rneg_q ? -ACCW'(iter_res) : ACCW'(iter_res);
	assign q_sat = sat_w(q_x);

	// Raw plane coefficient for plane cnt_q, row row_q: -(m3 +/- mj), or -m2 for plane 4.
	always_comb begin
		raw_sum = '0;
		case (cnt_q[2:0])
			3'd0: raw_sum = ACCW'(mrow_q[3]) + ACCW'(mrow_q[0]);
			3'd1: raw_sum = ACCW'(mrow_q[3]) - ACCW'(mrow_q[0]);
			3'd2: raw_sum = ACCW'(mrow_q[3]) - ACCW'(mrow_q[1]);
			3'd3: raw_sum = ACCW'(mrow_q[3]) + ACCW'(mrow_q[1]);
			3'd4: raw_sum = ACCW'(mrow_q[2]);
			3'd5: raw_sum = ACCW'(mrow_q[3]) - ACCW'(mrow_q[2]);
			default: raw_sum = '0;
		endcase
		raw_new = sat_w(-raw_sum);
	end

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbc_pkg::S_IDLE: begin
				if (accept && req.data.req_type == fbc_pkg::REQ_BUILD)
					state_d = fbc_pkg::S_BMUL;
				else if (accept && req.data.req_type == fbc_pkg::REQ_TEST)
					state_d = fbc_pkg::S_TEST;
			end
			fbc_pkg::S_BMUL: begin
				if (cnt_q == 4'd15)
					state_d = fbc_pkg::S_BDRAIN;
			end
			fbc_pkg::S_BDRAIN: state_d = fbc_pkg::S_BRAW;
			fbc_pkg::S_BRAW: begin
				if (cnt_q == 4'd5)
					state_d = (row_q == 2'd3) ? fbc_pkg::S_NSQ : fbc_pkg::S_BMUL;
			end
			fbc_pkg::S_NSQ: begin
				if (cnt_q[1:0] == 2'd2)
					state_d = fbc_pkg::S_NDRAIN;
			end
			fbc_pkg::S_NDRAIN:     state_d = fbc_pkg::S_NROOT_GO;
			fbc_pkg::S_NROOT_GO:   state_d = fbc_pkg::S_NROOT_WAIT;
			fbc_pkg::S_NROOT_WAIT: begin
				if (iter_done)
					state_d = fbc_pkg::S_NDIV_GO;
			end
			fbc_pkg::S_NDIV_GO: begin
				if (len_q != '0)
					state_d = fbc_pkg::S_NDIV_WAIT;
				else if (last_k)
					state_d = last_p ? fbc_pkg::S_IDLE : fbc_pkg::S_NSQ;
			end
			fbc_pkg::S_NDIV_WAIT: begin
				if (iter_done) begin
					if (last_k)
						state_d = last_p ? fbc_pkg::S_IDLE : fbc_pkg::S_NSQ;
					else
						state_d = fbc_pkg::S_NDIV_GO;
				end
			end
			fbc_pkg::S_TEST: begin
				if (last_k && last_p)
					state_d = fbc_pkg::S_TDRAIN;
			end
			fbc_pkg::S_TDRAIN: state_d = fbc_pkg::S_DONE;
			fbc_pkg::S_DONE: begin
				if (res_free)
					state_d = fbc_pkg::S_IDLE;
			end
			default: state_d = fbc_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs (operand selection and unit control)
	// ------------------------------------------------------------------
	always_comb begin
		issue         = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		mul_tag       = '{first: 1'b0, last: 1'b0, col: 2'd0, kind: fbc_pkg::ACC_VP};
		iter_ctl      = '{start: 1'b0, sqrt_mode: 1'b0};
		req.ready     = 1'b0;
		unique case (state_q)
			fbc_pkg::S_IDLE: req.ready = 1'b1;
			fbc_pkg::S_BMUL: begin
				// view[r][k] * proj[k][c], k fastest
				issue   = 1'b1;
				mul_a   = MAW'(view_q[{row_q, cnt_q[1:0]}]);
				mul_b   = proj_q[{cnt_q[1:0], cnt_q[3:2]}];
				mul_tag = '{first: (cnt_q[1:0] == 2'd0), last: last_k,
				            col: cnt_q[3:2], kind: fbc_pkg::ACC_VP};
			end
			fbc_pkg::S_NSQ: begin
				issue   = 1'b1;
				mul_a   = MAW'(raw_sel);
				mul_b   = raw_sel;
				mul_tag = '{first: (cnt_q[1:0] == 2'd0), last: (cnt_q[1:0] == 2'd2),
				            col: 2'd0, kind: fbc_pkg::ACC_SQ};
			end
			fbc_pkg::S_NROOT_GO: iter_ctl = '{start: 1'b1, sqrt_mode: 1'b1};
			fbc_pkg::S_NDIV_GO:  iter_ctl = '{start: (len_q != '0), sqrt_mode: 1'b0};
			fbc_pkg::S_TEST: begin
				// pick the corner nearest along the normal; w enters as w * 1.0
				issue = 1'b1;
				mul_b = pl_sel;
				if (last_k)
					mul_a = ONE_A;
				else if (pl_sel[EW-1])
					mul_a = mx_q[cnt_q[1:0]];
				else
					mul_a = mn_q[cnt_q[1:0]];
				mul_tag = '{first: (cnt_q[1:0] == 2'd0), last: last_k,
				            col: 2'd0, kind: fbc_pkg::ACC_DOT};
			end
			default: ;
		endcase
	end

	fbc_iter #(
		.EW (EW),
		.FB (FB)
	) u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (iter_ctl),
		.num      ({raw_abs, {FB{1'b0}}}),
		.radicand (acc_q[SQW-1:0]),
		.divisor  (len_q),
		.done     (iter_done),
		.result   (iter_res)
	);

	// ------------------------------------------------------------------
	// Shared multiplier, then accumulate in the following cycle
	// ------------------------------------------------------------------
	assign acc_sum = (ptag_s1.first ? '0 : acc_q) + ACCW'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		ptag_s1 <= mul_tag;
		if (pv_s1)
			acc_q <= acc_sum;
		if (pv_s1 && ptag_s1.last && ptag_s1.kind == fbc_pkg::ACC_VP)
			mrow_q[ptag_s1.col] <= sat_w(acc_sum >>> FB);
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbc_pkg::S_IDLE;
			cnt_q        <= '0;
			row_q        <= '0;
			pl_q         <= '0;
			pv_s1        <= 1'b0;
			outside_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_inside_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= issue;

			// a dot product above zero puts the box outside that plane
			if (pv_s1 && ptag_s1.last && ptag_s1.kind == fbc_pkg::ACC_DOT &&
			    !acc_sum[ACCW-1] && acc_sum != '0)
				outside_q <= 1'b1;

			if (res.ready)
				out_valid_q <= 1'b0;
			if (state_q == fbc_pkg::S_DONE && res_free) begin
				out_valid_q  <= 1'b1;
				out_inside_q <= !outside_q;
			end

			case (state_q)
				fbc_pkg::S_IDLE: begin
					if (accept) begin
						cnt_q     <= '0;
						row_q     <= '0;
						pl_q      <= '0;
						outside_q <= 1'b0;
					end
				end
				fbc_pkg::S_BMUL, fbc_pkg::S_TEST: begin
					cnt_q <= cnt_q + 1'b1;
					if (state_q == fbc_pkg::S_TEST && last_k)
						pl_q <= pl_q + 1'b1;
				end
				fbc_pkg::S_BRAW: begin
					if (cnt_q == 4'd5) begin
						cnt_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				fbc_pkg::S_NSQ: begin
					cnt_q <= (cnt_q[1:0] == 2'd2) ? 4'd0 : cnt_q + 1'b1;
				end
				fbc_pkg::S_NROOT_WAIT: begin
					if (iter_done)
						cnt_q <= '0;
				end
				default: ;
			endcase

			// advance to the next coefficient once one is written
			if (adv) begin
				if (last_k) begin
					cnt_q <= '0;
					pl_q  <= pl_q + 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == fbc_pkg::S_BRAW)
			raw_q[{cnt_q[2:0], row_q}] <= raw_new;
		if (state_q == fbc_pkg::S_NROOT_WAIT && iter_done)
			len_q <= iter_res[LW-1:0];
		if (state_q == fbc_pkg::S_NDIV_GO)
			rneg_q <= raw_sel[EW-1];
		if (accept && req.data.req_type == fbc_pkg::REQ_TEST) begin
			mn_q[0] <= MAW'(req.data.center_x) - $signed({3'b000, req.data.extent_x});
			mn_q[1] <= MAW'(req.data.center_y) - $signed({3'b000, req.data.extent_y});
			mn_q[2] <= MAW'(req.data.center_z) - $signed({3'b000, req.data.extent_z});
			mx_q[0] <= MAW'(req.data.center_x) + $signed({3'b000, req.data.extent_x});
			mx_q[1] <= MAW'(req.data.center_y) + $signed({3'b000, req.data.extent_y});
			mx_q[2] <= MAW'(req.data.center_z) + $signed({3'b000, req.data.extent_z});
		end
	end

	// Matrix and plane stores carry reset values: identity and zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				view_q[i] <= (i % 5 == 0) ? DIAG : '0;
				proj_q[i] <= (i % 5 == 0) ? DIAG : '0;
			end
			for (int i = 0; i < 24; i++)
				plane_q[i] <= '0;
		end else begin
			if (accept && req.data.req_type == fbc_pkg::REQ_LOAD_VIEW)
				view_q[{req.data.row, req.data.col}] <= entry_sat;
			if (accept && req.data.req_type == fbc_pkg::REQ_LOAD_PROJ)
				proj_q[{req.data.row, req.data.col}] <= entry_sat;
			// zero-length normal: store the plane as all zero
			if (state_q == fbc_pkg::S_NDIV_GO && len_q == '0)
				plane_q[sidx] <= '0;
			if (state_q == fbc_pkg::S_NDIV_WAIT && iter_done)
				plane_q[sidx] <= q_sat;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.data.inside_res = out_inside_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_iter_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		iter_done |-> (state_q == fbc_pkg::S_NROOT_WAIT ||
		               state_q == fbc_pkg::S_NDIV_WAIT))
		else $error("shift-subtract unit finished outside a wait state");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbc_pkg::S_DONE |-> !pv_s1)
		else $error("product still in flight when the result is formed");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fbc_pkg::S_DONE))
		else $error("result raised without a finished box test");

	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.data.req_type == fbc_pkg::REQ_TEST) |=>
		(state_q == fbc_pkg::S_TEST && cnt_q == '0 && pl_q == '0))
		else $error("box test transfer did not start the plane sweep");

endmodule
